// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int COL_W_DEF  = $clog2(COLUMNS_DEF);
	localparam int ROW_W_DEF  = $clog2(ROWS_DEF);
	localparam int ADDR_W_DEF = $clog2(COLUMNS_DEF * ROWS_DEF);

	localparam int CMD_W  = 2;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int CELL_W = CHAR_W + ATTR_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

	localparam int TAB_STEP = 8;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic sweep;
		logic init;
		logic load_exec;
		logic load_result;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_needed;
		logic item_read;
		logic sweep_last;
		logic out_free;
	} ctrl_sts_t;

endpackage

// ===== rtl/tcw_if.sv =====
interface tcw_in_if #(
	parameter int ADDR_W = tcw_pkg::ADDR_W_DEF
);
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::CMD_W-1:0]   cmd;
	logic [tcw_pkg::CHAR_W-1:0]  char_code;
	logic [ADDR_W-1:0]           cell_address;

	modport source(output valid, cmd, char_code, cell_address, input ready);
	modport sink(input valid, cmd, char_code, cell_address, output ready);
endinterface

interface tcw_out_if #(
	parameter int ROW_W = tcw_pkg::ROW_W_DEF,
	parameter int COL_W = tcw_pkg::COL_W_DEF
);
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::CELL_W-1:0]  read_data;
	logic [ROW_W-1:0]            cursor_row;
	logic [COL_W-1:0]            cursor_col;

	modport source(output valid, read_data, cursor_row, cursor_col, input ready);
	modport sink(input valid, read_data, cursor_row, cursor_col, output ready);
endinterface

interface tcw_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::ATTR_W-1:0]  text_attribute;

	modport source(output valid, text_attribute, input ready);
	modport sink(input valid, text_attribute, output ready);
endinterface

// ===== rtl/text_console_character_writer.sv =====
// put, return, tab and newline without scroll: latched when taken, then executed, and the
// cursor goes straight to the result register if it is free, else via the result state;
// a read goes through the registered screen read and the result state; scroll and clear
// walk every cell first. A new item is taken only once the sequencer is back in idle.
// reset: cursor homes, attribute is 0x0F, then a clearing pass over all ROWS*COLUMNS cells
// fills the screen with blanks while no item is taken; config writes still land
module text_console_character_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tcw_in_if.sink     req,
	tcw_out_if.source  rsp,
	tcw_cfg_if.sink    cfg
);

	// control and status between the sequencer and the datapath
	tcw_pkg::ctrl_cmd_t ctrl_cmd;
	tcw_pkg::ctrl_sts_t ctrl_sts;
	logic               req_ready;

	// sequencer: reset clearing pass, item execute, scroll/clear sweep, result hand-off
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (ctrl_sts),
		.cmd       (ctrl_cmd)
	);

	// item transfer happens only while the sequencer is idle
	assign req.ready = req_ready;

	// screen memory, cursor, attribute register and result register
	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (ctrl_cmd),
		.sts              (ctrl_sts),
		.req_cmd          (req.cmd),
		.req_char_code    (req.char_code),
		.req_cell_address (req.cell_address),
		.rsp              (rsp),
		.cfg              (cfg)
	);

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  tcw_pkg::ctrl_sts_t    sts,
	output tcw_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_INIT   = 5'b00001,
		S_IDLE   = 5'b00010,
		S_EXEC   = 5'b00100,
		S_SWEEP  = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.sweep = 1'b1;
				cmd.init  = 1'b1;
				if (sts.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				priority if (sts.sweep_needed) begin
					state_d = S_SWEEP;
				end else if (sts.item_read) begin
					state_d = S_RESULT;
				end else if (sts.out_free) begin
					cmd.load_exec = 1'b1;
					state_d       = S_IDLE;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/tcw_datapath.sv =====
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  tcw_pkg::ctrl_cmd_t                     cmd,
	output tcw_pkg::ctrl_sts_t                     sts,
	input  logic [tcw_pkg::CMD_W-1:0]              req_cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]             req_char_code,
	input  logic [$clog2(ROWS*COLUMNS)-1:0]        req_cell_address,
	tcw_out_if.source                              rsp,
	tcw_cfg_if.sink                                cfg
);

	localparam int CELLS       = ROWS * COLUMNS;
	localparam int COPY_CELLS  = (ROWS - 1) * COLUMNS;
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int ROW_W       = $clog2(ROWS);
	localparam int ADDR_W      = $clog2(CELLS);
	localparam int CELL_W      = tcw_pkg::CELL_W;

	localparam logic [COL_W:0]    TAB_ADD  = (COL_W+1)'(tcw_pkg::TAB_STEP);
	localparam logic [COL_W:0]    TAB_MASK = ~((COL_W+1)'(tcw_pkg::TAB_STEP - 1));
	localparam logic [COL_W:0]    COL_LIM  = (COL_W+1)'(COLUMNS);
	localparam logic [ROW_W:0]    ROW_LIM  = (ROW_W+1)'(ROWS);
	localparam logic [ADDR_W:0]   CELL_LIM = (ADDR_W+1)'(CELLS);
	localparam logic [ADDR_W:0]   COPY_LIM = (ADDR_W+1)'(COPY_CELLS);
	localparam logic [ADDR_W-1:0] LAST_CNT = ADDR_W'(CELLS - 1);

	// latched item
	logic [tcw_pkg::CMD_W-1:0]   cmd_q;
	logic [tcw_pkg::CHAR_W-1:0]  char_q;
	logic [ADDR_W-1:0]           addr_q;

	logic [ROW_W-1:0]            row_q;
	logic [COL_W-1:0]            col_q;
	logic [tcw_pkg::ATTR_W-1:0]  attr_q;

	logic [CELL_W-1:0]           mem_q [CELLS];
	logic [CELL_W-1:0]           rd_data_q;
	logic                        rd_hit_q;

	logic [ADDR_W-1:0]           cnt_q;
	logic                        copy_q;
	logic                        wr_valid_s1;
	logic                        wr_copy_s1;
	logic                        wr_init_s1;
	logic [ADDR_W-1:0]           wr_addr_s1;

	logic                        out_valid_q;
	logic [CELL_W-1:0]           out_data_q;
	logic [ROW_W-1:0]            out_row_q;
	logic [COL_W-1:0]            out_col_q;

	logic                        is_put, is_read, is_clear;
	logic                        is_nl, is_cr, is_tab, is_plain;
	logic [COL_W:0]              col_inc, tab_col;
	logic [ROW_W:0]              row_inc;
	logic                        wrap, scroll;
	logic [ROW_W-1:0]            next_row;
	logic [COL_W-1:0]            next_col;
	logic [ADDR_W-1:0]           cur_addr;
	logic                        addr_ok;
	logic                        sweep_copy;
	logic [ADDR_W:0]             src_full;

	logic                        wr_en, rd_en;
	logic [ADDR_W-1:0]           wr_addr, rd_addr;
	logic [CELL_W-1:0]           wr_data, blank;

	// item decode and cursor motion
	always_comb begin
		is_put   = (cmd_q == tcw_pkg::CMD_PUT);
		is_read  = (cmd_q == tcw_pkg::CMD_READ);
		is_clear = (cmd_q == tcw_pkg::CMD_CLEAR);
		is_nl    = is_put && (char_q == tcw_pkg::CH_NEWLINE);
		is_cr    = is_put && (char_q == tcw_pkg::CH_RETURN);
		is_tab   = is_put && (char_q == tcw_pkg::CH_TAB);
		is_plain = is_put && !is_nl && !is_cr && !is_tab;

		col_inc = {1'b0, col_q} + (COL_W+1)'(1);
		tab_col = ({1'b0, col_q} + TAB_ADD) & TAB_MASK;
		row_inc = {1'b0, row_q} + (ROW_W+1)'(1);

		wrap   = is_nl || (is_tab && (tab_col >= COL_LIM))
			|| (is_plain && (col_inc >= COL_LIM));
		scroll = wrap && (row_inc >= ROW_LIM);

		next_row = row_q;
		next_col = col_q;
		if (is_clear) begin
			next_row = '0;
			next_col = '0;
		end else if (wrap) begin
			next_col = '0;
			if (!scroll) next_row = row_inc[ROW_W-1:0];
		end else if (is_cr) begin
			next_col = '0;
		end else if (is_tab) begin
			next_col = tab_col[COL_W-1:0];
		end else if (is_plain) begin
			next_col = col_inc[COL_W-1:0];
		end

		cur_addr = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
		addr_ok  = ({1'b0, addr_q} < CELL_LIM);
	end

	// sweep: read one row ahead, write the registered data in the cycle after
	always_comb begin
		sweep_copy = copy_q && !cmd.init && ({1'b0, cnt_q} < COPY_LIM);
		src_full   = {1'b0, cnt_q} + (ADDR_W+1)'(COLUMNS);
		blank      = wr_init_s1 ? {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE}
			: {attr_q, tcw_pkg::CH_SPACE};

		wr_en   = 1'b0;
		wr_addr = wr_addr_s1;
		wr_data = wr_copy_s1 ? rd_data_q : blank;
		if (wr_valid_s1) begin
			wr_en = 1'b1;
		end else if (cmd.exec && is_plain) begin
			wr_en   = 1'b1;
			wr_addr = cur_addr;
			wr_data = {attr_q, char_q};
		end

		rd_en   = 1'b0;
		rd_addr = addr_q;
		if (cmd.sweep) begin
			rd_en   = sweep_copy;
			rd_addr = src_full[ADDR_W-1:0];
		end else if (cmd.exec) begin
			rd_en = is_read && addr_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cmd_q  <= req_cmd;
			char_q <= req_char_code;
			addr_q <= req_cell_address;
		end
		if (cmd.exec) copy_q <= scroll;
		wr_addr_s1 <= cnt_q;
		wr_copy_s1 <= sweep_copy;
		wr_init_s1 <= cmd.init;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			attr_q      <= tcw_pkg::ATTR_RESET;
			cnt_q       <= '0;
			wr_valid_s1 <= 1'b0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (cfg.valid) attr_q <= cfg.text_attribute;
			if (cmd.exec) begin
				row_q    <= next_row;
				col_q    <= next_col;
				rd_hit_q <= is_read && addr_ok;
				cnt_q    <= '0;
			end else if (cmd.sweep) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			wr_valid_s1 <= cmd.sweep;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_exec || cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_exec) begin
			out_data_q <= '0;
			out_row_q  <= next_row;
			out_col_q  <= next_col;
		end else if (cmd.load_result) begin
			out_data_q <= rd_hit_q ? rd_data_q : '0;
			out_row_q  <= row_q;
			out_col_q  <= col_q;
		end
	end

	assign sts.sweep_needed = scroll || is_clear;
	assign sts.item_read    = is_read;
	assign sts.sweep_last   = (cnt_q == LAST_CNT);
	assign sts.out_free     = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.read_data  = out_data_q;
	assign rsp.cursor_row = out_row_q;
	assign rsp.cursor_col = out_col_q;

	assign cfg.ready = 1'b1;

endmodule
